/* rtl/fixed_font_text_renderer_defines.svh */
// assertion macros for the fixed font text renderer
// depends on signals named clk and rst_n in the module that uses them
`ifndef FIXED_FONT_TEXT_RENDERER_DEFINES_SVH
`define FIXED_FONT_TEXT_RENDERER_DEFINES_SVH
`ifndef SYNTHESIS
`define FFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFR_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FFR_ASSERT(label, prop, msg)
`define FFR_NEVER(label, expr, msg)
`endif
`endif

/* rtl/ffr_pkg.sv */
// shared types and constants of the fixed font text renderer
// no dependencies
package ffr_pkg;

  localparam int GLYPH_COUNT_DEF = 256;
  localparam int GLYPH_COLS      = 5;
  localparam int GLYPH_ROWS      = 8;
  localparam int CELL_PITCH      = 6;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DRAW  = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_RETURN  = 8'd13;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [7:0] WIDTH_RESET  = 8'd128;
  localparam logic [7:0] HEIGHT_RESET = 8'd64;

  typedef struct packed {
    logic [1:0]  command;
    logic [10:0] font_address;
    logic [7:0]  font_byte;
    logic [7:0]  origin_x;
    logic [7:0]  origin_y;
    logic [15:0] text_color;
    logic [15:0] back_color;
    logic [7:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [15:0] pixel_color;
  } pixel_t;

  typedef struct packed {
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic   push;
    logic   flush;
    pixel_t pixel;
  } emit_ctrl_t;

  typedef struct packed {
    logic ready;
    logic pend_valid;
  } emit_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ROWS,
    ST_FLUSH
  } state_t;

endpackage

/* rtl/ffr_emit.sv */
// pixel emit stage: one pending pixel plus the output register
// depends on ffr_pkg; the pending slot lets the final pixel carry the last flag
module ffr_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  ffr_pkg::emit_ctrl_t ctrl,
  output ffr_pkg::emit_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output ffr_pkg::out_item_t  out_item
);

  logic               pend_valid_r, pend_valid_nxt;
  ffr_pkg::pixel_t    pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  ffr_pkg::out_item_t out_r, out_nxt;
  logic               slot_free;

  assign slot_free       = !out_valid_r || out_ready;
  assign stat.ready      = !pend_valid_r || slot_free;
  assign stat.pend_valid = pend_valid_r;
  assign out_valid       = out_valid_r;
  assign out_item        = out_r;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.push && stat.ready) begin
      if (pend_valid_r) begin
        out_nxt       = {pend_r, 1'b0};
        out_valid_nxt = 1'b1;
      end
      pend_nxt       = ctrl.pixel;
      pend_valid_nxt = 1'b1;
    end else if (ctrl.flush && pend_valid_r && slot_free) begin
      out_nxt        = {pend_r, 1'b1};
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

/* rtl/fixed_font_text_renderer.sv */
// top level of the 5x8 fixed font text renderer
// depends on ffr_pkg, ffr_emit and fixed_font_text_renderer_defines.svh
//
// usage:
//   in channel (in_valid/in_ready/in_item) takes one command per item:
//   load a font byte, start text at an origin with colors, or draw a character.
//   out channel (out_valid/out_ready/out_item) gives pixel writes, last set on
//   the final pixel of a character. cfg_* is an apb-style port holding
//   display_width at 0x0 and display_height at 0x4 (low 8 bits used).
// sequencing:
//   load, start, newline, carriage return and clipped characters leave in_ready
//   high. a drawn character is accepted, then each glyph column has a font read
//   state followed by a scan of its 8 rows; opaque text adds a blank sixth
//   column with no font read. a flush state then hands over the final pixel.
//   in_ready is low while a character is being drawn.
// reset:
//   cursor, origin and colors clear to zero, width 128, height 64; the glyph
//   store is not cleared and must be loaded before use.
// stalls:
//   when out_ready is low the sequencer holds on the current row until the
//   output register drains; no pixel is dropped or repeated.
`include "fixed_font_text_renderer_defines.svh"
module fixed_font_text_renderer #(
  parameter int GLYPH_COUNT = ffr_pkg::GLYPH_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ffr_pkg::in_item_t   in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ffr_pkg::out_item_t  out_item,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int STORE_DEPTH = GLYPH_COUNT * ffr_pkg::GLYPH_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // glyph store, undefined until loaded
  logic [7:0] glyph_mem [STORE_DEPTH];
  logic [7:0] rd_data_r;
  logic       mem_we, rd_en;
  logic [10:0] rd_addr;

  // control and cursor state
  ffr_pkg::state_t state_r, state_nxt;
  logic [7:0]  width_r, height_r;
  logic [7:0]  home_x_r, home_x_nxt, home_y_r, home_y_nxt;
  logic [7:0]  cursor_col_r, cursor_col_nxt, cursor_row_r, cursor_row_nxt;
  logic [15:0] fore_r, fore_nxt, back_r, back_nxt;

  // per-character draw context
  logic [7:0]  x0_r, x0_nxt, y0_r, y0_nxt;
  logic [10:0] base_r, base_nxt;
  logic        blank_r, blank_nxt, opaque_r, opaque_nxt;
  logic [2:0]  col_r, col_nxt, row_r, row_nxt;

  logic        accept, cfg_write;
  logic [8:0]  pitch_sum;
  logic        wrap, clip;
  logic [7:0]  col_w, row_w;
  logic [7:0]  col_bits;
  logic        bit_set, cand, advance;

  ffr_pkg::emit_ctrl_t ectrl;
  ffr_pkg::emit_stat_t estat;

  assign in_ready   = (state_r == ffr_pkg::ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  // register reads
  always_comb begin
    unique case (cfg_paddr[2])
      ffr_pkg::REG_WIDTH:  cfg_prdata = {24'd0, width_r};
      ffr_pkg::REG_HEIGHT: cfg_prdata = {24'd0, height_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ffr_pkg::WIDTH_RESET;
      height_r <= ffr_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_paddr[2])
        ffr_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[7:0];
        ffr_pkg::REG_HEIGHT: height_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // wrap and clip decision for a drawn character, from the current cursor
  assign pitch_sum = {1'b0, cursor_col_r} + 9'(ffr_pkg::CELL_PITCH);
  assign wrap      = pitch_sum > {1'b0, width_r};
  assign col_w     = wrap ? home_x_r : cursor_col_r;
  assign row_w     = wrap ? cursor_row_r + 8'(ffr_pkg::GLYPH_ROWS) : cursor_row_r;
  assign clip      = (col_w >= width_r) || (row_w >= height_r);

  // current glyph column bits; the sixth column and codes past the font are blank
  assign col_bits = (col_r == 3'(ffr_pkg::GLYPH_COLS) || blank_r) ? 8'd0 : rd_data_r;
  assign bit_set  = col_bits[row_r];
  assign cand     = (state_r == ffr_pkg::ST_ROWS) && (bit_set || opaque_r);
  assign advance  = !cand || estat.ready;

  // coordinate adders feeding the emit stage
  assign ectrl.push              = cand;
  assign ectrl.flush             = (state_r == ffr_pkg::ST_FLUSH);
  assign ectrl.pixel.pixel_x     = {1'b0, x0_r} + 9'(col_r);
  assign ectrl.pixel.pixel_y     = {1'b0, y0_r} + 9'(row_r);
  assign ectrl.pixel.pixel_color = bit_set ? fore_r : back_r;

  assign rd_addr = base_r + 11'(col_r);
  assign rd_en   = (state_r == ffr_pkg::ST_READ);
  assign mem_we  = accept && (in_item.command == ffr_pkg::CMD_LOAD)
                   && (in_item.font_address < 11'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[in_item.font_address[ADDR_W-1:0]] <= in_item.font_byte;
    end
    if (rd_en) begin
      rd_data_r <= glyph_mem[rd_addr[ADDR_W-1:0]];
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    home_x_nxt     = home_x_r;
    home_y_nxt     = home_y_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    fore_nxt       = fore_r;
    back_nxt       = back_r;
    x0_nxt         = x0_r;
    y0_nxt         = y0_r;
    base_nxt       = base_r;
    blank_nxt      = blank_r;
    opaque_nxt     = opaque_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    unique case (state_r)
      ffr_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_item.command)
            ffr_pkg::CMD_START: begin
              home_x_nxt     = in_item.origin_x;
              home_y_nxt     = in_item.origin_y;
              fore_nxt       = in_item.text_color;
              back_nxt       = in_item.back_color;
              cursor_col_nxt = in_item.origin_x;
              cursor_row_nxt = in_item.origin_y;
            end
            ffr_pkg::CMD_DRAW: begin
              if (in_item.char_code == ffr_pkg::CHAR_NEWLINE) begin
                cursor_col_nxt = home_x_r;
                cursor_row_nxt = cursor_row_r + 8'(ffr_pkg::GLYPH_ROWS);
              end else if (in_item.char_code != ffr_pkg::CHAR_RETURN) begin
                cursor_col_nxt = col_w + 8'(ffr_pkg::CELL_PITCH);
                cursor_row_nxt = row_w;
                x0_nxt         = col_w;
                y0_nxt         = row_w;
                // code times five as shift and add
                base_nxt       = {1'b0, in_item.char_code, 2'b00} + {3'b000, in_item.char_code};
                blank_nxt      = {1'b0, in_item.char_code} >= 9'(GLYPH_COUNT);
                opaque_nxt     = fore_r != back_r;
                col_nxt        = 3'd0;
                row_nxt        = 3'd0;
                if (!clip) begin
                  state_nxt = ffr_pkg::ST_READ;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ffr_pkg::ST_READ: begin
        state_nxt = ffr_pkg::ST_ROWS;
      end
      ffr_pkg::ST_ROWS: begin
        if (advance) begin
          if (row_r == 3'(ffr_pkg::GLYPH_ROWS - 1)) begin
            row_nxt = 3'd0;
            if (col_r == 3'(ffr_pkg::GLYPH_COLS)
                || (col_r == 3'(ffr_pkg::GLYPH_COLS - 1) && !opaque_r)) begin
              state_nxt = ffr_pkg::ST_FLUSH;
            end else begin
              col_nxt = col_r + 3'd1;
              if (col_r != 3'(ffr_pkg::GLYPH_COLS - 1)) begin
                state_nxt = ffr_pkg::ST_READ;
              end
            end
          end else begin
            row_nxt = row_r + 3'd1;
          end
        end
      end
      ffr_pkg::ST_FLUSH: begin
        if (estat.ready) begin
          state_nxt = ffr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ffr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffr_pkg::ST_IDLE;
      home_x_r     <= 8'd0;
      home_y_r     <= 8'd0;
      cursor_col_r <= 8'd0;
      cursor_row_r <= 8'd0;
      fore_r       <= 16'd0;
      back_r       <= 16'd0;
      col_r        <= 3'd0;
      row_r        <= 3'd0;
    end else begin
      state_r      <= state_nxt;
      home_x_r     <= home_x_nxt;
      home_y_r     <= home_y_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      fore_r       <= fore_nxt;
      back_r       <= back_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
    end
  end

  // draw context needs no reset, it is loaded before each character
  always_ff @(posedge clk) begin
    x0_r     <= x0_nxt;
    y0_r     <= y0_nxt;
    base_r   <= base_nxt;
    blank_r  <= blank_nxt;
    opaque_r <= opaque_nxt;
  end

  ffr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ectrl),
    .stat      (estat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // no pixel may be left pending once a new item can be taken
  `FFR_NEVER(a_idle_no_pending, in_ready && estat.pend_valid, "pixel pending while idle")
  // anything still waiting at idle is the final pixel of a character
  `FFR_NEVER(a_idle_out_last, in_ready && out_valid && !out_item.last, "non-final pixel at idle")
  // the blank sixth column only exists for opaque text
  `FFR_NEVER(a_sixth_col_opaque,
    (state_r != ffr_pkg::ST_IDLE) && (col_r == 3'(ffr_pkg::GLYPH_COLS)) && !opaque_r,
    "sixth column drawn for transparent text")
  // column counter stays within the glyph cell
  `FFR_NEVER(a_col_range, col_r > 3'(ffr_pkg::GLYPH_COLS), "column counter out of range")
  // a font read is always followed by row scanning
  `FFR_ASSERT(a_read_then_rows, state_r == ffr_pkg::ST_READ |=> state_r == ffr_pkg::ST_ROWS,
    "font read not followed by row scan")

endmodule

/* sim/tb_fixed_font_text_renderer.sv */
// self-checking bench for fixed_font_text_renderer: font loads, text starts and characters
// in, pixel writes checked one by one against a local prediction of the renderer
// depends on ffr_pkg and rtl/fixed_font_text_renderer.sv
module tb_fixed_font_text_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  // command code 3 has no meaning in the block, used as noise
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int FONT_DEPTH = ffr_pkg::GLYPH_COUNT_DEF * ffr_pkg::GLYPH_COLS;
  // idle wait after the last owed pixel, so that a character with no pixels can finish
  localparam int DRAIN_CYCLES = 64;
  localparam longint CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_COUNT = 6;

  // one line of the directed script
  typedef struct {
    ffr_pkg::in_item_t  item;
    bit                 typed;
    int                 n_pix;
    ffr_pkg::out_item_t first;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  ffr_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ffr_pkg::out_item_t out_item;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [2:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  fixed_font_text_renderer dut (.*);

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // local copy of the renderer state
  // ---------------------------------------------------------------------------
  logic [7:0]  font_mem [FONT_DEPTH];
  bit          font_known [FONT_DEPTH];
  bit          code_ready [ffr_pkg::GLYPH_COUNT_DEF];
  // codes with all five columns loaded, the only ones ever drawn
  logic [7:0]  drawable [$];
  logic [7:0]  home_x = '0, home_y = '0, cursor_col = '0, cursor_row = '0;
  logic [15:0] fore_color = '0, back_fill = '0;
  logic [7:0]  disp_w = ffr_pkg::WIDTH_RESET, disp_h = ffr_pkg::HEIGHT_RESET;

  // pixel writes still owed by the block, oldest first
  ffr_pkg::out_item_t pending_pixels [$];
  int                 error_count = 0;
  longint             cycle_count = 0;

  task automatic flag_error(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic ffr_pkg::out_item_t px(input int x, input int y,
                                            input logic [15:0] color);
    ffr_pkg::out_item_t p;
    p.pixel_x = 9'(x);
    p.pixel_y = 9'(y);
    p.pixel_color = color;
    p.last = 1'b0;
    return p;
  endfunction

  // update the state for one accepted item and queue the pixels it causes
  task automatic render_item(input ffr_pkg::in_item_t it, output int n,
                             output ffr_pkg::out_item_t first);
    ffr_pkg::out_item_t pix [$];
    logic [7:0] bits;
    bit         opaque;
    bit         whole;
    int         code;
    n = 0;
    first = '0;
    case (it.command)
      ffr_pkg::CMD_LOAD: begin
        // addresses past the font are dropped
        if (it.font_address < FONT_DEPTH) begin
          font_mem[it.font_address] = it.font_byte;
          font_known[it.font_address] = 1'b1;
          code = it.font_address / ffr_pkg::GLYPH_COLS;
          whole = 1'b1;
          for (int c = 0; c < ffr_pkg::GLYPH_COLS; c++)
            whole &= font_known[code * ffr_pkg::GLYPH_COLS + c];
          if (whole && !code_ready[code]) begin
            code_ready[code] = 1'b1;
            drawable.push_back(8'(code));
          end
        end
      end
      ffr_pkg::CMD_START: begin
        home_x = it.origin_x;
        home_y = it.origin_y;
        fore_color = it.text_color;
        back_fill = it.back_color;
        cursor_col = it.origin_x;
        cursor_row = it.origin_y;
      end
      ffr_pkg::CMD_DRAW: begin
        if (it.char_code == ffr_pkg::CHAR_NEWLINE) begin
          cursor_col = home_x;
          cursor_row = cursor_row + 8'(ffr_pkg::GLYPH_ROWS);
        end else if (it.char_code != ffr_pkg::CHAR_RETURN) begin
          // wrap when the cell would cross the right edge, full-width sum
          if (9'(cursor_col) + 9'(ffr_pkg::CELL_PITCH) > 9'(disp_w)) begin
            cursor_col = home_x;
            cursor_row = cursor_row + 8'(ffr_pkg::GLYPH_ROWS);
          end
          if (cursor_col < disp_w && cursor_row < disp_h) begin
            opaque = fore_color != back_fill;
            for (int c = 0; c < ffr_pkg::GLYPH_COLS; c++) begin
              bits = font_mem[it.char_code * ffr_pkg::GLYPH_COLS + c];
              for (int r = 0; r < ffr_pkg::GLYPH_ROWS; r++)
                if (bits[r] || opaque)
                  pix.push_back(px(cursor_col + c, cursor_row + r,
                                   bits[r] ? fore_color : back_fill));
            end
            // blank sixth column only when opaque
            if (opaque)
              for (int r = 0; r < ffr_pkg::GLYPH_ROWS; r++)
                pix.push_back(px(cursor_col + ffr_pkg::GLYPH_COLS, cursor_row + r,
                                 back_fill));
            if (pix.size() > 0) begin
              pix[pix.size() - 1].last = 1'b1;
              first = pix[0];
            end
          end
          cursor_col = cursor_col + 8'(ffr_pkg::CELL_PITCH);
        end
      end
      default: ;
    endcase
    n = pix.size();
    foreach (pix[i]) pending_pixels.push_back(pix[i]);
  endtask

  // ---------------------------------------------------------------------------
  // item builders, unused fields carry random junk
  // ---------------------------------------------------------------------------
  function automatic ffr_pkg::in_item_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(ffr_pkg::in_item_t)-1:0];
  endfunction

  function automatic ffr_pkg::in_item_t mk_load(input logic [10:0] addr,
                                                input logic [7:0] data);
    ffr_pkg::in_item_t it;
    it = noise_item();
    it.command = ffr_pkg::CMD_LOAD;
    it.font_address = addr;
    it.font_byte = data;
    return it;
  endfunction

  function automatic ffr_pkg::in_item_t mk_start(input logic [7:0] x, input logic [7:0] y,
                                                 input logic [15:0] fg,
                                                 input logic [15:0] bg);
    ffr_pkg::in_item_t it;
    it = noise_item();
    it.command = ffr_pkg::CMD_START;
    it.origin_x = x;
    it.origin_y = y;
    it.text_color = fg;
    it.back_color = bg;
    return it;
  endfunction

  function automatic ffr_pkg::in_item_t mk_char(input logic [7:0] code);
    ffr_pkg::in_item_t it;
    it = noise_item();
    it.command = ffr_pkg::CMD_DRAW;
    it.char_code = code;
    return it;
  endfunction

  function automatic ffr_pkg::in_item_t mk_unused();
    ffr_pkg::in_item_t it;
    it = noise_item();
    it.command = CMD_UNUSED;
    return it;
  endfunction

  function automatic script_row_t plain(input ffr_pkg::in_item_t it);
    script_row_t row;
    row.item = it;
    row.typed = 1'b0;
    row.n_pix = 0;
    row.first = '0;
    return row;
  endfunction

  function automatic script_row_t typed(input ffr_pkg::in_item_t it, input int n,
                                        input ffr_pkg::out_item_t first);
    script_row_t row;
    row.item = it;
    row.typed = 1'b1;
    row.n_pix = n;
    row.first = first;
    return row;
  endfunction

  // origin mostly inside the visible area so that text gets drawn
  function automatic ffr_pkg::in_item_t random_start();
    logic [7:0]  x, y;
    logic [15:0] fg, bg;
    x = ($urandom_range(3) != 0) ? 8'($urandom_range(disp_w - 1)) : 8'($urandom);
    y = ($urandom_range(3) != 0) ? 8'($urandom_range(disp_h - 1)) : 8'($urandom);
    fg = 16'($urandom);
    case ($urandom_range(3))
      0: bg = fg;
      1: begin
        fg = 16'hFFFF;
        bg = 16'h0000;
      end
      default: bg = 16'($urandom);
    endcase
    return mk_start(x, y, fg, bg);
  endfunction

  // mostly text on loaded glyphs, with line breaks, font updates and noise
  function automatic ffr_pkg::in_item_t pick_item();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return random_start();
    if (roll < 13) return mk_load(11'($urandom_range(2047)), 8'($urandom));
    if (roll < 15) return mk_unused();
    if (roll < 23) return mk_char(ffr_pkg::CHAR_NEWLINE);
    if (roll < 26) return mk_char(ffr_pkg::CHAR_RETURN);
    return mk_char(drawable[$urandom_range(drawable.size() - 1)]);
  endfunction

  // ---------------------------------------------------------------------------
  // input side: bursts of items with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit sender_steady = 1'b0;

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12, 1);
      gap = sender_steady ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // valid stays high after acceptance, the caller lowers it or sends again
  task automatic send_item(input ffr_pkg::in_item_t it, output int n,
                           output ffr_pkg::out_item_t first);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    render_item(it, n, first);
  endtask

  // stop sending, wait for every owed pixel and let a silent item finish
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic write, input logic reg_idx,
                            input logic [7:0] value, output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= {reg_idx, 2'b00};
    // upper bits are not part of the register
    cfg_pwdata <= {24'($urandom), value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic check_display();
    logic [31:0] rd;
    apb_access(1'b0, ffr_pkg::REG_WIDTH, 8'd0, rd);
    if (rd[7:0] !== disp_w) flag_error($sformatf("width reads %0d, want %0d", rd[7:0], disp_w));
    apb_access(1'b0, ffr_pkg::REG_HEIGHT, 8'd0, rd);
    if (rd[7:0] !== disp_h) flag_error($sformatf("height reads %0d, want %0d", rd[7:0], disp_h));
  endtask

  task automatic set_display(input logic [7:0] w, input logic [7:0] h);
    logic [31:0] unused_rd;
    apb_access(1'b1, ffr_pkg::REG_WIDTH, w, unused_rd);
    apb_access(1'b1, ffr_pkg::REG_HEIGHT, h, unused_rd);
    disp_w = w;
    disp_h = h;
    check_display();
  endtask

  // ---------------------------------------------------------------------------
  // output side: random short stalls, with steady windows every third slot
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(negedge clk) begin
    if ((cycle_count / 700) % 3 == 0) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(5) == 0) stall_left <= $urandom_range(4, 1);
    end
  end

  task automatic check_pixel(input ffr_pkg::out_item_t got);
    ffr_pkg::out_item_t want;
    if (pending_pixels.size() == 0) begin
      flag_error($sformatf("pixel (%0d,%0d) color %h with nothing owed",
                           got.pixel_x, got.pixel_y, got.pixel_color));
      return;
    end
    want = pending_pixels.pop_front();
    if (got.pixel_x !== want.pixel_x)
      flag_error($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
    if (got.pixel_y !== want.pixel_y)
      flag_error($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
    if (got.pixel_color !== want.pixel_color)
      flag_error($sformatf("pixel_color %h, want %h at (%0d,%0d)",
                           got.pixel_color, want.pixel_color, want.pixel_x, want.pixel_y));
    if (got.last !== want.last)
      flag_error($sformatf("last %b, want %b at (%0d,%0d)",
                           got.last, want.last, want.pixel_x, want.pixel_y));
  endtask

  // cycle count, run limit and result monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_fixed_font_text_renderer failed");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      check_pixel(out_item);
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    script_row_t        script [$];
    int                 n;
    ffr_pkg::out_item_t first;
    logic [7:0]         code;
    logic [7:0]         w, h;
    int                 phase_w [PHASE_COUNT] = '{255, 1, 255, 1, 0, 128};
    int                 phase_h [PHASE_COUNT] = '{255, 1, 1, 255, 0, 64};
    int                 phase_len [PHASE_COUNT] = '{50, 20, 30, 30, 60, 70};

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // registers come up at their reset values, then get written once
    check_display();
    set_display(ffr_pkg::WIDTH_RESET, ffr_pkg::HEIGHT_RESET);

    // font: blank glyph 0, solid glyph 255, a mixed glyph 1, then random glyphs
    for (int c = 0; c < ffr_pkg::GLYPH_COLS; c++) begin
      pace();
      send_item(mk_load(11'(c), 8'h00), n, first);
      pace();
      send_item(mk_load(11'(255 * ffr_pkg::GLYPH_COLS + c), 8'hFF), n, first);
    end
    begin
      logic [7:0] mixed [ffr_pkg::GLYPH_COLS] = '{8'h01, 8'h80, 8'h55, 8'hAA, 8'h00};
      for (int c = 0; c < ffr_pkg::GLYPH_COLS; c++) begin
        pace();
        send_item(mk_load(11'(ffr_pkg::GLYPH_COLS + c), mixed[c]), n, first);
      end
    end
    repeat (20) begin
      code = 8'($urandom_range(254, 2));
      for (int c = 0; c < ffr_pkg::GLYPH_COLS; c++) begin
        pace();
        send_item(mk_load(11'(code * ffr_pkg::GLYPH_COLS + c), 8'($urandom)), n, first);
      end
    end

    // directed script, display 128 x 64
    script.push_back(typed(mk_load(11'd2047, 8'hA5), 0, '0));  // load past the font
    script.push_back(typed(mk_load(11'd1280, 8'h3C), 0, '0));  // first address past the font
    script.push_back(typed(mk_unused(), 0, '0));
    script.push_back(typed(mk_start(8'd0, 8'd0, 16'hFFFF, 16'hFFFF), 0, '0));
    // transparent solid glyph: 40 set pixels
    script.push_back(typed(mk_char(8'd255), 40, px(0, 0, 16'hFFFF)));
    // transparent blank glyph: nothing at all
    script.push_back(typed(mk_char(8'd0), 0, '0));
    script.push_back(typed(mk_char(ffr_pkg::CHAR_RETURN), 0, '0));
    script.push_back(typed(mk_char(ffr_pkg::CHAR_NEWLINE), 0, '0));
    script.push_back(plain(mk_char(8'd1)));
    script.push_back(typed(mk_start(8'd0, 8'd0, 16'h0000, 16'hFFFF), 0, '0));
    // opaque: always 48 pixels, blank glyph is all background
    script.push_back(typed(mk_char(8'd0), 48, px(0, 0, 16'hFFFF)));
    script.push_back(typed(mk_char(8'd255), 48, px(6, 0, 16'h0000)));
    // cell that ends exactly on the right edge still fits
    script.push_back(typed(mk_start(8'd122, 8'd56, 16'h1234, 16'h1234), 0, '0));
    script.push_back(typed(mk_char(8'd255), 40, px(122, 56, 16'h1234)));
    // wraps below the bottom edge: clipped
    script.push_back(typed(mk_char(8'd255), 0, '0));
    script.push_back(typed(mk_start(8'd120, 8'd50, 16'hAAAA, 16'h5555), 0, '0));
    script.push_back(plain(mk_char(8'd1)));
    script.push_back(plain(mk_char(8'd1)));
    // origin past the right edge: wraps back to itself and is clipped
    script.push_back(typed(mk_start(8'd255, 8'd255, 16'hFFFF, 16'h0000), 0, '0));
    script.push_back(typed(mk_char(8'd255), 0, '0));
    script.push_back(typed(mk_char(ffr_pkg::CHAR_NEWLINE), 0, '0));
    // row counter wraps from 255 to 7 on a newline
    script.push_back(typed(mk_start(8'd0, 8'd255, 16'hFFFF, 16'h0000), 0, '0));
    script.push_back(typed(mk_char(ffr_pkg::CHAR_NEWLINE), 0, '0));
    script.push_back(typed(mk_char(8'd255), 48, px(0, 7, 16'hFFFF)));
    script.push_back(plain(mk_char(8'd1)));

    foreach (script[i]) begin
      pace();
      send_item(script[i].item, n, first);
      if (script[i].typed && (n != script[i].n_pix || (n > 0 && first !== script[i].first)))
        flag_error($sformatf("script row %0d gives %0d pixels, want %0d", i, n,
                             script[i].n_pix));
    end

    // random phases over several display sizes, extremes included
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain();
      w = (phase_w[ph] != 0) ? 8'(phase_w[ph]) : 8'($urandom_range(255, 6));
      h = (phase_h[ph] != 0) ? 8'(phase_h[ph]) : 8'($urandom_range(255, 1));
      set_display(w, h);
      sender_steady = (ph % 3 == 2);
      for (int k = 0; k < phase_len[ph]; k++) begin
        pace();
        send_item((k == 0) ? random_start() : pick_item(), n, first);
      end
    end

    drain();
    if (error_count == 0) begin
      $display("tb_fixed_font_text_renderer passed");
    end else begin
      $display("tb_fixed_font_text_renderer failed");
    end
    $finish;
  end

endmodule
